// File: src/lfwd_pkg.sv
// package for the lowest free worker dispatch block
// request and response payload types, field widths and worker pool defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfwd_pkg;

    localparam int TIME_W     = 31;
    localparam int AMOUNT_W   = 30;
    localparam int FREE_W     = 32;
    localparam int TOTAL_W    = 48;
    localparam int INDEX_W    = 4;

    localparam int WORKER_COUNT_DEF = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0]   arrival_time;
        logic [AMOUNT_W-1:0] job_amount;
        logic [TIME_W-1:0]   busy_duration;
    } req_t;

    typedef struct packed {
        logic                served;
        logic [INDEX_W-1:0]  worker_index;
        logic [TOTAL_W-1:0]  worker_total;
    } rsp_t;

endpackage

`default_nettype wire

// File: src/lowest_free_worker_dispatch.sv
// a request is held in the request register and its response in the response register
// throughput: one request per cycle, set by the single pass from the request register
// through the free time compare, priority encode and total add while rsp_stall is low
// reset: asynchronous active low, all free times and totals clear to zero, all workers free
// top level of the lowest free worker dispatch block, depends on lfwd_pkg and lfwd_pick
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_worker_dispatch #(
    parameter int WORKER_COUNT = lfwd_pkg::WORKER_COUNT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire lfwd_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output lfwd_pkg::rsp_t      rsp
);

    localparam int IDX_W = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

    logic                         req_valid_reg;
    lfwd_pkg::req_t               req_reg;
    logic                         rsp_valid_reg;
    lfwd_pkg::rsp_t               rsp_reg;
    lfwd_pkg::rsp_t               rsp_next;

    logic [lfwd_pkg::FREE_W-1:0]  free_at_reg [WORKER_COUNT];
    logic [lfwd_pkg::TOTAL_W-1:0] total_reg   [WORKER_COUNT];

    logic                         found;
    logic [IDX_W-1:0]             pick;
    logic [IDX_W+3:0]             pick_ext;
    logic                         advance;
    logic                         take;
    logic [lfwd_pkg::TOTAL_W:0]   sum;
    logic [lfwd_pkg::TOTAL_W-1:0] total_next;
    logic [lfwd_pkg::FREE_W-1:0]  free_next;

    lfwd_pick #(
        .WORKER_COUNT (WORKER_COUNT),
        .IDX_W        (IDX_W)
    ) u_pick (
        .free_at      (free_at_reg),
        .arrival_time (req_reg.arrival_time),
        .found        (found),
        .pick         (pick)
    );

    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    assign sum        = {1'b0, total_reg[pick]} + (lfwd_pkg::TOTAL_W + 1)'(req_reg.job_amount);
    assign total_next = sum[lfwd_pkg::TOTAL_W] ? lfwd_pkg::TOTAL_MAX
                                               : sum[lfwd_pkg::TOTAL_W-1:0];
    assign free_next  = {1'b0, req_reg.arrival_time} + {1'b0, req_reg.busy_duration};
    assign pick_ext   = {4'b0, pick};

    always_comb
    begin
        rsp_next = '0;
        if (found)
        begin
            rsp_next.served       = 1'b1;
            rsp_next.worker_index = pick_ext[3:0];
            rsp_next.worker_total = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // worker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WORKER_COUNT; k++)
            begin
                free_at_reg[k] <= '0;
                total_reg[k]   <= '0;
            end
        end
        else if (advance && found)
        begin
            free_at_reg[pick] <= free_next;
            total_reg[pick]   <= total_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> req_valid_reg)
        else $error("request stall raised with no held request");

    a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("processed request produced no response");

    a_found_served: assert property (@(posedge clk) disable iff (!rst_n)
        advance && found |=> rsp_reg.served)
        else $error("free worker found but response not served");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !found |=> !rsp_reg.served && rsp_reg.worker_index == '0
                              && rsp_reg.worker_total == '0)
        else $error("dropped request response not cleared");

    a_busy_after_serve: assert property (@(posedge clk) disable iff (!rst_n)
        advance && found |=> free_at_reg[$past(pick)] == $past(free_next))
        else $error("serving worker free time not updated");
`endif

endmodule

`default_nettype wire

// File: src/lfwd_pick.sv
// lowest index free worker search
// compares every free time against the job time and priority encodes the result
// depends on lfwd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfwd_pick #(
    parameter int WORKER_COUNT = lfwd_pkg::WORKER_COUNT_DEF,
    parameter int IDX_W        = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1
) (
    input  wire logic [lfwd_pkg::FREE_W-1:0] free_at [WORKER_COUNT],
    input  wire logic [lfwd_pkg::TIME_W-1:0] arrival_time,
    output logic                             found,
    output logic [IDX_W-1:0]                 pick
);

    logic [WORKER_COUNT-1:0]      is_free;
    logic [lfwd_pkg::FREE_W-1:0]  when_ext;

    assign when_ext = {1'b0, arrival_time};

    always_comb
    begin
        for (int k = 0; k < WORKER_COUNT; k++)
        begin
            is_free[k] = (free_at[k] <= when_ext);
        end
    end

    // lowest set bit wins
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int k = WORKER_COUNT - 1; k >= 0; k--)
        begin
            if (is_free[k])
            begin
                found = 1'b1;
                pick  = IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire
